// ===== design/mlc_pkg.sv =====
// Package: shared types, codes and constants of the motion/lux light controller.
`default_nettype none

package mlc_pkg;

	localparam int LUX_W   = 16;
	localparam int CFG_W   = 8;
	localparam int HOLD_W  = 11;
	localparam int SETTLE_W = 3;
	localparam int DIM_W   = 6;
	localparam int PROD_W  = 38;

	// floor(x * 14 / 10) = floor(x * 7 * ceil(2^21 / 5) / 2^21) for x < 2^16
	localparam int RECIP_SHIFT = 21;
	localparam logic [21:0] SETTLE_RECIP = 22'(7 * ((2 ** RECIP_SHIFT + 4) / 5));

	localparam logic [LUX_W-1:0]    LUX_MAX      = '1;
	localparam logic [SETTLE_W-1:0] SETTLE_SECS  = 3'd5;
	localparam logic [CFG_W-1:0]    THR_RESET    = 8'd10;
	localparam logic [CFG_W-1:0]    HOLD_RESET   = 8'd12;

	// configuration register indexes
	localparam logic CFG_LUX_THRESHOLD = 1'b0;
	localparam logic CFG_HOLD_SETTING  = 1'b1;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_MOTION = 2'd1,
		CMD_LUX    = 2'd2,
		CMD_MODE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ON     = 2'd1,
		MODE_SENSOR = 2'd2,
		MODE_REST   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		LIGHT_OFF  = 2'd0,
		LIGHT_DIM  = 2'd1,
		LIGHT_FULL = 2'd2
	} light_t;

	typedef struct packed {
		cmd_t             cmd;
		logic             motion_level;
		logic [LUX_W-1:0] lux_value;
		mode_t            new_mode;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] lux_threshold;
		logic [CFG_W-1:0] hold_setting;
	} cfg_t;

	typedef struct packed {
		light_t              light_state;
		mode_t               mode_reg;
		logic [LUX_W-1:0]    last_lux;
		logic [LUX_W-1:0]    off_level;
		logic [HOLD_W-1:0]   hold_count;
		logic                hold_armed;
		logic [SETTLE_W-1:0] settle_count;
		logic                settle_armed;
	} state_t;

	typedef logic [DIM_W-1:0] dim_tab_t [256];

	// round(sqrt(7.5*h)) = n where (2n-1)^2 <= 30h < (2n+1)^2; built at elaboration
	function automatic dim_tab_t build_dim_tab();
		dim_tab_t tab;
		int x;
		int n;
		for (int h = 0; h < 256; h++) begin
			x = 30 * h;
			n = 0;
			while ((2 * n + 1) * (2 * n + 1) <= x) begin
				n++;
			end
			tab[h] = DIM_W'(n);
		end
		return tab;
	endfunction

	localparam dim_tab_t DIM_TAB = build_dim_tab();

endpackage

`default_nettype wire

// ===== design/mlc_if.sv =====
// Interfaces: valid/ready channels for event items and result items.
`default_nettype none

interface mlc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        motion_level;
	logic [15:0] lux_value;
	logic [1:0]  new_mode;

	modport source (output valid, cmd, motion_level, lux_value, new_mode, input ready);
	modport sink   (input valid, cmd, motion_level, lux_value, new_mode, output ready);
endinterface

interface mlc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  light_level;
	logic        lamp_lit;
	logic [1:0]  mode_now;
	logic [15:0] lux_off_level;

	modport source (output valid, light_level, lamp_lit, mode_now, lux_off_level, input ready);
	modport sink   (input valid, light_level, lamp_lit, mode_now, lux_off_level, output ready);
endinterface

`default_nettype wire

// ===== design/mlc_step.sv =====
// Next-state logic: applies one event to the controller state.
`default_nettype none

module mlc_step (
	input  mlc_pkg::state_t cur,
	input  mlc_pkg::cfg_t   cfg,
	input  mlc_pkg::item_t  item,
	output mlc_pkg::state_t nxt
);
	import mlc_pkg::*;

	logic [HOLD_W-1:0] thr5;
	logic [HOLD_W-1:0] thr7;
	logic [HOLD_W-1:0] hold5;
	logic [PROD_W-1:0] prod;
	logic [16:0]       scaled;
	logic [LUX_W-1:0]  scaled_sat;
	logic [LUX_W-1:0]  settle_level;
	light_t            light_dn;

	assign thr5  = {3'b0, cfg.lux_threshold} * 11'd5;
	assign thr7  = {3'b0, cfg.lux_threshold} * 11'd7;
	assign hold5 = {3'b0, cfg.hold_setting} * 11'd5;

	// last_lux * 1.4, floored and saturated
	assign prod       = {22'b0, cur.last_lux} * {16'b0, SETTLE_RECIP};
	assign scaled     = prod[RECIP_SHIFT +: 17];
	assign scaled_sat = scaled[16] ? LUX_MAX : scaled[LUX_W-1:0];
	assign settle_level = ({5'b0, thr7} > scaled_sat) ? {5'b0, thr7} : scaled_sat;

	always_comb begin
		case (cur.light_state)
			LIGHT_FULL: light_dn = LIGHT_DIM;
			default:    light_dn = LIGHT_OFF;
		endcase
	end

	always_comb begin
		nxt = cur;
		case (item.cmd)
			CMD_TICK: begin
				if (cur.settle_armed) begin
					if (cur.settle_count <= 3'd1) begin
						nxt.settle_armed = 1'b0;
						nxt.settle_count = '0;
						nxt.off_level    = settle_level;
					end else begin
						nxt.settle_count = cur.settle_count - 3'd1;
					end
				end
				if (cur.hold_armed) begin
					if (cur.hold_count <= 11'd1) begin
						nxt.light_state = light_dn;
						if (light_dn == LIGHT_DIM) begin
							nxt.hold_armed = 1'b1;
							nxt.hold_count = {5'b0, DIM_TAB[cfg.hold_setting]};
						end else begin
							nxt.hold_armed = 1'b0;
							nxt.hold_count = '0;
						end
					end else begin
						nxt.hold_count = cur.hold_count - 11'd1;
					end
				end
			end
			CMD_MOTION: begin
				if (cur.mode_reg == MODE_SENSOR) begin
					if (item.motion_level) begin
						if (cur.last_lux <= {5'b0, thr5}) begin
							nxt.hold_armed   = 1'b0;
							nxt.hold_count   = '0;
							nxt.off_level    = LUX_MAX;
							nxt.light_state  = LIGHT_FULL;
							nxt.settle_count = SETTLE_SECS;
							nxt.settle_armed = 1'b1;
						end
					end else begin
						nxt.hold_count = hold5;
						nxt.hold_armed = 1'b1;
					end
				end
			end
			CMD_LUX: begin
				nxt.last_lux = item.lux_value;
				if (cur.light_state != LIGHT_OFF && item.lux_value > cur.off_level) begin
					nxt.light_state = LIGHT_OFF;
				end
				if (cur.mode_reg == MODE_REST && item.lux_value > {5'b0, thr7}) begin
					nxt.mode_reg = MODE_SENSOR;
				end
			end
			CMD_MODE: begin
				nxt.mode_reg = item.new_mode;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/motion_lux_light_controller_unit.sv =====
// Top level: motion- and lux-driven lamp controller with event and result channels.
`default_nettype none

// Each event beat (tick, motion edge, lux sample, mode change) yields exactly one
// result beat describing the light, mode and lux-off level after that event.
// Sustained rate is one beat per cycle while rsp is ready; an accepted event is held
// in the input register, then makes one pass through the next-state logic (a 16x22
// multiply for the lux-off level, a few compares and a 256-entry dim-time table) into
// the state and result registers. The result
// register lets the next event be taken while a result waits on the consumer.
// Configuration writes (index 0 lux threshold, index 1 hold setting) take effect
// at once and belong only in idle periods.

module motion_lux_light_controller_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_index,
	input  wire logic [7:0] cfg_wdata,
	mlc_req_if.sink       req,
	mlc_rsp_if.source     rsp
);
	import mlc_pkg::*;

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nxt;
	item_t  item_s1;
	logic   valid_s1;
	logic   advance;

	logic       rsp_valid_q;
	light_t     light_q;
	logic       lit_q;
	mode_t      mode_q;
	logic [LUX_W-1:0] off_q;

	// advance the input stage whenever the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	mlc_step u_step (
		.cur  (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (st_nxt)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lux_threshold <= THR_RESET;
			cfg_q.hold_setting  <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LUX_THRESHOLD: cfg_q.lux_threshold <= cfg_wdata;
				CFG_HOLD_SETTING:  cfg_q.hold_setting  <= cfg_wdata;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// control: input stage valid, controller state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q.light_state  <= LIGHT_OFF;
			st_q.mode_reg     <= MODE_OFF;
			st_q.last_lux     <= '0;
			st_q.off_level    <= LUX_MAX;
			st_q.hold_count   <= '0;
			st_q.hold_armed   <= 1'b0;
			st_q.settle_count <= '0;
			st_q.settle_armed <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				st_q        <= st_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: capture the event beat, then the result beat; hold while stalled
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd          <= cmd_t'(req.cmd);
			item_s1.motion_level <= req.motion_level;
			item_s1.lux_value    <= req.lux_value;
			item_s1.new_mode     <= mode_t'(req.new_mode);
		end
		if (advance) begin
			light_q <= st_nxt.light_state;
			lit_q   <= (st_nxt.mode_reg == MODE_ON) || (st_nxt.light_state != LIGHT_OFF);
			mode_q  <= st_nxt.mode_reg;
			off_q   <= st_nxt.off_level;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.light_level   = light_q;
	assign rsp.lamp_lit      = lit_q;
	assign rsp.mode_now      = mode_q;
	assign rsp.lux_off_level = off_q;

endmodule

`default_nettype wire

// ===== sim/motion_lux_light_controller_unit_tb.sv =====
// Testbench: motion_lux_light_controller_unit under random traffic, checked against a local model.
`default_nettype none

// Event beats go in on req and one result beat comes back on rsp for every event.
// A clocked driver feeds req from a queue of pending events. A clocked monitor
// keeps its own copy of the controller state and pushes the expected result when
// an event beat is accepted. It pops and compares the expectation when a result
// beat is accepted. Inputs change on the falling edge and everything is sampled on
// the rising edge.
//
// The run is in phases. Each phase writes the two registers while the block is
// drained, then queues a mix of well-formed light cycles and random events:
//   auto or sleep mode -> dark lux sample -> motion on -> ticks -> motion off -> ticks
// The ticks run the settle and hold timers out.

module motion_lux_light_controller_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mlc_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 250;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		light_t           light_level;
		logic             lamp_lit;
		mode_t            mode_now;
		logic [LUX_W-1:0] lux_off_level;
	} lamp_view_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	mlc_req_if req_ch ();
	mlc_rsp_if rsp_ch ();

	motion_lux_light_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Local copy of the controller: registers and state.
	int               thr_reg  = int'(THR_RESET);
	int               hold_reg = int'(HOLD_RESET);
	light_t           lamp     = LIGHT_OFF;
	mode_t            mode_cur = MODE_OFF;
	logic [LUX_W-1:0] seen_lux = '0;
	logic [LUX_W-1:0] lux_off  = LUX_MAX;
	int               hold_left   = 0;
	logic             hold_on     = 1'b0;
	int               settle_left = 0;
	logic             settle_on   = 1'b0;

	item_t      pending[$];     // events waiting for the driver
	lamp_view_t lamp_due[$];    // results the block still owes

	int   errs = 0;
	int   cycles = 0;
	int   idle_pct = 0;         // odds in percent of starting an idle burst
	int   src_gap = 0;
	int   snk_gap = 0;
	logic req_fired = 1'b0;

	// Values the stimulus side last wrote to the registers.
	int cur_thr  = int'(THR_RESET);
	int cur_hold = int'(HOLD_RESET);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Seconds of dim before the light goes off: round(sqrt(7.5 * h)).
	// The answer is n when (2n-1)^2 <= 30h < (2n+1)^2.
	function automatic int dim_hold_secs(int h);
		int n;
		n = 0;
		while ((2 * n + 1) * (2 * n + 1) <= 30 * h)
			n++;
		return n;
	endfunction

	// Apply one event to the local state and return what the block should report.
	function automatic lamp_view_t apply_event(item_t ev);
		lamp_view_t view;
		int         off_calc;
		case (ev.cmd)
			CMD_TICK: begin
				// Settle goes first. On expiry, recompute the lux-off level from the last sample.
				if (settle_on) begin
					if (settle_left <= 1) begin
						settle_on = 1'b0;
						settle_left = 0;
						off_calc = (int'(seen_lux) * 14) / 10;
						if (off_calc > 65535)
							off_calc = 65535;
						if (7 * thr_reg > off_calc)
							off_calc = 7 * thr_reg;
						lux_off = off_calc[LUX_W-1:0];
					end else begin
						settle_left--;
					end
				end
				// On hold expiry, step the light down one level. On reaching dim, re-arm for the dim time.
				if (hold_on) begin
					if (hold_left <= 1) begin
						hold_on = 1'b0;
						hold_left = 0;
						if (lamp != LIGHT_OFF)
							lamp = light_t'(lamp - 1);
						if (lamp == LIGHT_DIM) begin
							hold_left = dim_hold_secs(hold_reg);
							hold_on = 1'b1;
						end
					end else begin
						hold_left--;
					end
				end
			end
			CMD_MOTION: begin
				if (mode_cur == MODE_SENSOR) begin
					if (ev.motion_level) begin
						if (int'(seen_lux) <= 5 * thr_reg) begin
							hold_on = 1'b0;
							hold_left = 0;
							lux_off = LUX_MAX;
							lamp = LIGHT_FULL;
							settle_left = int'(SETTLE_SECS);
							settle_on = 1'b1;
						end
					end else begin
						hold_left = 5 * hold_reg;
						hold_on = 1'b1;
					end
				end
			end
			CMD_LUX: begin
				seen_lux = ev.lux_value;
				if (lamp != LIGHT_OFF && ev.lux_value > lux_off)
					lamp = LIGHT_OFF;
				if (mode_cur == MODE_REST && int'(ev.lux_value) > 7 * thr_reg)
					mode_cur = MODE_SENSOR;
			end
			default: begin
				mode_cur = ev.new_mode;
			end
		endcase
		view.light_level   = lamp;
		view.lamp_lit      = (mode_cur == MODE_ON) || (lamp != LIGHT_OFF);
		view.mode_now      = mode_cur;
		view.lux_off_level = lux_off;
		return view;
	endfunction

	// Driver: present the next event after the previous beat went through, or idle.
	always @(negedge clk) begin : drive_req
		item_t nxt;
		if (arst_n) begin
			if (!req_ch.valid || req_fired) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					req_ch.valid <= 1'b0;
				end else if ($urandom_range(0, 99) < idle_pct) begin
					src_gap <= $urandom_range(0, 11);
					req_ch.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					nxt = pending.pop_front();
					req_ch.cmd          <= nxt.cmd;
					req_ch.motion_level <= nxt.motion_level;
					req_ch.lux_value    <= nxt.lux_value;
					req_ch.new_mode     <= nxt.new_mode;
					req_ch.valid        <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			// The result side stalls in bursts of its own.
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				snk_gap <= $urandom_range(0, 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: track register writes, predict on accepted events, check accepted results.
	always @(posedge clk) begin : watch
		lamp_view_t want;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("motion_lux_light_controller_unit_tb: done, errors");
			$finish;
		end
		if (!arst_n) begin
			req_fired <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LUX_THRESHOLD: thr_reg = int'(cfg_wdata);
					CFG_HOLD_SETTING:  hold_reg = int'(cfg_wdata);
					default: ;
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (lamp_due.size() == 0) begin
					$error("result beat with no event outstanding");
					errs++;
				end else begin
					want = lamp_due.pop_front();
					if (rsp_ch.light_level !== want.light_level) begin
						$error("light_level: expected %0d, got %0d",
							want.light_level, rsp_ch.light_level);
						errs++;
					end
					if (rsp_ch.lamp_lit !== want.lamp_lit) begin
						$error("lamp_lit: expected %0d, got %0d",
							want.lamp_lit, rsp_ch.lamp_lit);
						errs++;
					end
					if (rsp_ch.mode_now !== want.mode_now) begin
						$error("mode_now: expected %0d, got %0d",
							want.mode_now, rsp_ch.mode_now);
						errs++;
					end
					if (rsp_ch.lux_off_level !== want.lux_off_level) begin
						$error("lux_off_level: expected %0d, got %0d",
							want.lux_off_level, rsp_ch.lux_off_level);
						errs++;
					end
				end
			end
			// An accepted event causes a result through the input and result registers, never on this edge.
			if (req_ch.valid && req_ch.ready) begin
				lamp_due.push_back(apply_event(item_t'({cmd_t'(req_ch.cmd),
					req_ch.motion_level, req_ch.lux_value, mode_t'(req_ch.new_mode)})));
			end
			req_fired <= req_ch.valid && req_ch.ready;
		end
	end

	// Queue one event. Each push helper fills the fields its command ignores with noise.
	task automatic push_event(cmd_t c, logic lvl, int lux, mode_t md);
		item_t ev;
		ev.cmd          = c;
		ev.motion_level = lvl;
		ev.lux_value    = lux[LUX_W-1:0];
		ev.new_mode     = md;
		pending.push_back(ev);
	endtask

	task automatic push_tick();
		push_event(CMD_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 65535),
			mode_t'($urandom_range(0, 3)));
	endtask

	task automatic push_motion(logic lvl);
		push_event(CMD_MOTION, lvl, $urandom_range(0, 65535), mode_t'($urandom_range(0, 3)));
	endtask

	task automatic push_lux(int lux);
		push_event(CMD_LUX, 1'($urandom_range(0, 1)), lux, mode_t'($urandom_range(0, 3)));
	endtask

	task automatic push_mode(mode_t md);
		push_event(CMD_MODE, 1'($urandom_range(0, 1)), $urandom_range(0, 65535), md);
	endtask

	// Pick lux samples so that they land on the turn-on and turn-off edges often.
	function automatic int pick_lux();
		int v;
		int d;
		d = $urandom_range(0, 2);
		case ($urandom_range(0, 6))
			0, 1: v = $urandom_range(0, 5 * cur_thr);
			2:    v = 5 * cur_thr + d - 1;
			3:    v = 7 * cur_thr + d - 1;
			4:    v = $urandom_range(0, 65535);
			5:    v = $urandom_range(0, 1) ? 65535 : 0;
			default: v = $urandom_range(0, 10 * cur_thr + 20);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v;
	endfunction

	// One full light cycle with random timing and content.
	task automatic push_light_cycle();
		int dark;
		int n;
		int cap;
		int edge_lux;
		if ($urandom_range(0, 3) == 0) begin
			// Start in sleep and let a bright sample wake it, or just miss.
			push_mode(MODE_REST);
			push_lux(7 * cur_thr + $urandom_range(0, 2));
		end else begin
			push_mode(MODE_SENSOR);
		end
		dark = $urandom_range(0, 5 * cur_thr + 1);
		push_lux(dark);
		push_motion(1'b1);
		n = $urandom_range(0, 7);
		repeat (n) push_tick();
		if ($urandom_range(0, 2) == 0) begin
			// Sample right at the lux-off level that the settle timer sets.
			edge_lux = (14 * dark) / 10;
			if (edge_lux < 7 * cur_thr)
				edge_lux = 7 * cur_thr;
			push_lux(edge_lux + $urandom_range(0, 1));
		end
		push_motion(1'b0);
		cap = 5 * cur_hold + 8;
		if (cap > 60)
			cap = 60;
		n = $urandom_range(cap / 2, cap);
		repeat (n) push_tick();
		if ($urandom_range(0, 3) == 0)
			push_lux(pick_lux());
	endtask

	task automatic push_noise();
		push_event(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_lux(),
			mode_t'($urandom_range(0, 3)));
	endtask

	// Hold until every queued event went through and every result came back.
	// Check on the rising edge, where the driver's last beat is already visible.
	task automatic drain();
		while (pending.size() > 0 || req_ch.valid || lamp_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(int thr, int hold);
		drain();
		write_reg(CFG_LUX_THRESHOLD, thr);
		write_reg(CFG_HOLD_SETTING, hold);
		cur_thr  = thr;
		cur_hold = hold;
	endtask

	initial begin
		int thr_plan[PHASES];
		int hold_plan[PHASES];
		int idle_plan[PHASES];
		int start;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_LUX_THRESHOLD;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = CMD_TICK;
		req_ch.motion_level = 1'b0;
		req_ch.lux_value    = '0;
		req_ch.new_mode     = MODE_OFF;
		rsp_ch.ready        = 1'b0;

		thr_plan  = '{0, 255, 3, $urandom_range(0, 20), 0, 255, $urandom_range(0, 255), 10};
		hold_plan = '{0, 1, 2, $urandom_range(0, 3), 255, 255, 0, $urandom_range(0, 4)};
		idle_plan = '{20, 40, 10, 0, 25, 30, 15, 0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: threshold 10, so the light turns on at or below 50 and the sleep
		// wake and lux-off floor sit at 70. Hold 1 gives 5 s full and 3 s dim.
		idle_pct = 20;
		set_regs(10, 1);
		push_tick();                 // no timer armed
		push_motion(1'b1);           // ignored outside auto
		push_mode(MODE_ON);          // lit by mode alone
		push_mode(MODE_OFF);
		push_mode(MODE_REST);
		push_lux(70);                // at the wake level: stays asleep
		push_lux(71);                // above it: sleep lifts to auto
		push_motion(1'b1);           // too bright to turn on
		push_lux(50);
		push_motion(1'b1);           // dark enough: full, settle armed
		push_motion(1'b0);           // hold armed for 5 s
		repeat (5) push_tick();      // both timers expire on the same tick
		repeat (3) push_tick();      // dim time runs out: off
		push_motion(1'b1);
		push_lux(65535);             // equal to the lux-off level: stays on
		repeat (5) push_tick();      // settle from the brightest sample saturates

		for (int p = 0; p < PHASES; p++) begin
			set_regs(thr_plan[p], hold_plan[p]);
			idle_pct = idle_plan[p];
			start = pending.size();
			while (pending.size() - start < PHASE_BEATS) begin
				if ($urandom_range(0, 9) < 7)
					push_light_cycle();
				else
					push_noise();
			end
		end

		drain();
		repeat (6) @(negedge clk);
		if (errs == 0)
			$display("motion_lux_light_controller_unit_tb: done, clean");
		else
			$display("motion_lux_light_controller_unit_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
design/mlc_pkg.sv
design/mlc_if.sv
design/mlc_step.sv
design/motion_lux_light_controller_unit.sv
sim/motion_lux_light_controller_unit_tb.sv
